>>> hw/rtl/rhpm_pkg.sv
package rhpm_pkg;

   localparam int MaxPattern   = 64;
   localparam int CellCount    = MaxPattern + 1;
   localparam int LenBits      = $clog2(MaxPattern + 1);
   localparam int PosBits      = 20;
   localparam int HashBits     = 32;
   localparam int CharBits     = 8;
   localparam int ActionBits   = 2;

   localparam logic [HashBits-1:0] HashBase = HashBits'(31);

   typedef enum logic [ActionBits-1:0] {
      ACT_PATTERN    = 2'd0,
      ACT_TEXT       = 2'd1,
      ACT_CLEAR_ALL  = 2'd2,
      ACT_CLEAR_TEXT = 2'd3
   } action_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } chain_ctl_type;

   // Multiplicative inverse of an odd value modulo 2^HashBits (Newton iteration).
   function automatic logic [HashBits-1:0] odd_inverse(input logic [HashBits-1:0] a);
      logic [HashBits-1:0] x;
      x = a;
      for (int i = 0; i < 6; i++) begin
         x = x * (HashBits'(2) - a * x);
      end
      return x;
   endfunction

   localparam logic [HashBits-1:0] HashInvBase = odd_inverse(HashBase);

endpackage

>>> hw/rtl/rhpm_channels.sv
interface rhpm_req_if import rhpm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ActionBits-1:0] action;
   logic [CharBits-1:0]   ch;

   modport source (output valid, action, ch, input ready);
   modport sink   (input valid, action, ch, output ready);
endinterface

interface rhpm_rsp_if import rhpm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               match;
   logic [PosBits-1:0] start_pos;
   logic               pattern_full;

   modport source (output valid, match, start_pos, pattern_full, input ready);
   modport sink   (input valid, match, start_pos, pattern_full, output ready);
endinterface

>>> hw/rtl/rhpm_cell.sv
module rhpm_cell import rhpm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  chain_ctl_type       ctl,
   input  logic [LenBits-1:0]  index,
   input  logic [HashBits-1:0] d_value,
   input  logic                d_valid,
   input  logic [LenBits-1:0]  len,
   input  logic [HashBits-1:0] target,
   output logic [HashBits-1:0] q_value,
   output logic                q_valid,
   output logic                hit
);

   logic                is_head;
   logic [HashBits-1:0] value_ff;
   logic                valid_ff;

   // the head cell holds the empty prefix hash (zero) right after a clear
   assign is_head = (index == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= is_head;
      end else if (ctl.clear) begin
         valid_ff <= is_head;
      end else if (ctl.shift) begin
         valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         value_ff <= '0;
      end else if (ctl.shift) begin
         value_ff <= d_value;
      end
   end

   assign q_value = value_ff;
   assign q_valid = valid_ff;
   assign hit     = valid_ff && (index == len) && (value_ff == target);

endmodule

>>> hw/rtl/rhpm_chain.sv
module rhpm_chain import rhpm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  chain_ctl_type       ctl,
   input  logic [HashBits-1:0] head_value,
   input  logic [LenBits-1:0]  len,
   input  logic [HashBits-1:0] target,
   output logic                hit
);

   logic [HashBits-1:0] value_q [CellCount];
   logic                valid_q [CellCount];
   logic [CellCount-1:0] hits;

   for (genvar k = 0; k < CellCount; k++) begin : g_cell
      logic [HashBits-1:0] d_value;
      logic                d_valid;

      if (k == 0) begin : g_head
         assign d_value = head_value;
         assign d_valid = 1'b1;
      end else begin : g_body
         assign d_value = value_q[k-1];
         assign d_valid = valid_q[k-1];
      end

      rhpm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .index   (LenBits'(k)),
         .d_value (d_value),
         .d_valid (d_valid),
         .len     (len),
         .target  (target),
         .q_value (value_q[k]),
         .q_valid (valid_q[k]),
         .hit     (hits[k])
      );
   end

   assign hit = |hits;

endmodule

>>> hw/rtl/rolling_hash_pattern_matcher_unit.sv
// Streaming Rabin-Karp matcher (base 31, hashes mod 2^32). One transaction is taken per clock
// and gives one response through the compare and output registers; req_chan.ready drops only
// while both are full and rsp_chan is stalled. The first stage extends the text prefix hash
// and forms the value the window's leading prefix hash must equal (two 32x32 multiplies); the
// second compares it against a row of 65 cells that shift the recent prefix hashes along, the
// cell at the pattern length giving the hit. The pattern is held as its hash scaled by
// 31^-(len-1), so no power ring is needed. Collisions report as matches; an empty pattern never
// matches; pattern bytes past 64 are dropped with pattern_full set. Start positions wrap at 2^20.
module rolling_hash_pattern_matcher_unit import rhpm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   rhpm_req_if.sink   req_chan,
   rhpm_rsp_if.source rsp_chan
);

   // pattern and text state
   logic [HashBits-1:0] q_ff, q_in;
   logic [LenBits-1:0]  len_ff, len_in;
   logic [HashBits-1:0] hash_ff, hash_in;
   logic [HashBits-1:0] power_ff, power_in;
   logic [PosBits-1:0]  count_ff, count_in;

   // compare stage
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_text_ff, s1_text_in;
   logic                s1_full_ff, s1_full_in;
   logic [LenBits-1:0]  s1_len_ff, s1_len_in;
   logic [PosBits-1:0]  s1_start_ff, s1_start_in;
   logic [HashBits-1:0] s1_target_ff, s1_target_in;

   // output register
   logic                out_valid_ff, out_valid_in;
   logic                out_match_ff, out_match_in;
   logic [PosBits-1:0]  out_start_ff, out_start_in;
   logic                out_full_ff, out_full_in;

   logic                accept;
   logic                out_load;
   logic                s1_move;
   action_type          action;
   logic [HashBits-1:0] ch_ext;
   logic [HashBits-1:0] new_hash;
   logic [HashBits-1:0] scaled_pattern;
   chain_ctl_type       chain_ctl;
   logic                chain_hit;
   logic                match;

   assign out_load = !out_valid_ff || rsp_chan.ready;
   assign s1_move  = s1_valid_ff && out_load;
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign accept   = req_chan.valid && req_chan.ready;
   assign action   = action_type'(req_chan.action);
   assign ch_ext   = HashBits'(req_chan.ch);

   assign new_hash       = hash_ff + ch_ext * power_ff;
   // pattern_hash * 31^start, with start = count - len + 1
   assign scaled_pattern = power_ff * q_ff;

   always_comb begin
      q_in         = q_ff;
      len_in       = len_ff;
      hash_in      = hash_ff;
      power_in     = power_ff;
      count_in     = count_ff;
      s1_full_in   = 1'b0;
      s1_text_in   = 1'b0;
      chain_ctl    = '0;
      if (accept) begin
         case (action)
            ACT_PATTERN: begin
               if (len_ff < LenBits'(MaxPattern)) begin
                  q_in   = q_ff * HashInvBase + ch_ext;
                  len_in = len_ff + LenBits'(1);
               end else begin
                  s1_full_in = 1'b1;
               end
            end
            ACT_TEXT: begin
               s1_text_in      = 1'b1;
               hash_in         = new_hash;
               power_in        = power_ff * HashBase;
               count_in        = count_ff + PosBits'(1);
               chain_ctl.shift = 1'b1;
            end
            ACT_CLEAR_ALL: begin
               q_in            = '0;
               len_in          = '0;
               hash_in         = '0;
               power_in        = HashBits'(1);
               count_in        = '0;
               chain_ctl.clear = 1'b1;
            end
            ACT_CLEAR_TEXT: begin
               hash_in         = '0;
               power_in        = HashBits'(1);
               count_in        = '0;
               chain_ctl.clear = 1'b1;
            end
            default: begin
               chain_ctl = '0;
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      s1_len_in    = len_ff;
      s1_start_in  = count_ff - PosBits'(len_ff) + PosBits'(1);
      s1_target_in = new_hash - scaled_pattern;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff     <= '0;
         len_ff   <= '0;
         hash_ff  <= '0;
         power_ff <= HashBits'(1);
         count_ff <= '0;
      end else begin
         q_ff     <= q_in;
         len_ff   <= len_in;
         hash_ff  <= hash_in;
         power_ff <= power_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_text_ff   <= s1_text_in;
         s1_full_ff   <= s1_full_in;
         s1_len_ff    <= s1_len_in;
         s1_start_ff  <= s1_start_in;
         s1_target_ff <= s1_target_in;
      end
   end

   // cell k holds the prefix hash ending k bytes back; the cell at the pattern length
   // holds the hash just before the window once the stage-one byte has shifted in
   rhpm_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctl        (chain_ctl),
      .head_value (new_hash),
      .len        (s1_len_ff),
      .target     (s1_target_ff),
      .hit        (chain_hit)
   );

   assign match = s1_text_ff && (s1_len_ff != '0) && chain_hit;

   always_comb begin
      out_valid_in = out_load ? s1_valid_ff : out_valid_ff;
      out_match_in = match;
      out_start_in = match ? s1_start_ff : '0;
      out_full_in  = s1_full_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_match_ff <= out_match_in;
         out_start_ff <= out_start_in;
         out_full_ff  <= out_full_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.match        = out_match_ff;
   assign rsp_chan.start_pos    = out_start_ff;
   assign rsp_chan.pattern_full = out_full_ff;

   a_len_capped: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LenBits'(MaxPattern))
      else $error("pattern length beyond capacity");

   a_text_clear: assert property (@(posedge clock) disable iff (reset)
      accept && (action == ACT_CLEAR_TEXT || action == ACT_CLEAR_ALL)
      |=> count_ff == '0 && power_ff == HashBits'(1) && hash_ff == '0)
      else $error("text state not cleared");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_target_ff)
                                  && $stable(s1_len_ff))
      else $error("compare stage lost its transaction");

   a_match_text: assert property (@(posedge clock) disable iff (reset)
      s1_move && match |=> !out_full_ff && out_match_ff)
      else $error("match reported on a non-text transaction");

endmodule
